>>> sv/flrss_pkg.sv
// flrss_pkg: operation codes, status codes and fixed field widths for the
// free list record slot store; no dependencies
`default_nettype none

package flrss_pkg;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DELETED = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // fixed field widths of the stream payloads
  localparam int OP_W     = 2;
  localparam int SLOT_F_W = 10;
  localparam int DATA_F_W = 64;
  localparam int STAT_W   = 2;

  localparam int IN_BITS  = OP_W + SLOT_F_W + DATA_F_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STAT_W + SLOT_F_W + DATA_F_W + 1 + SLOT_F_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> sv/free_list_record_slot_store.sv
// free_list_record_slot_store: fixed-slot record store with a lifo free list
// held in one synchronous slot memory; uses flrss_pkg
`default_nettype none

// In each transaction the accept cycle issues one read of the
// slot memory (the free-list head for add, the addressed slot otherwise), and
// the execute state then uses the registered read data, writes the slot entry
// back and loads the result register once the output register is free. The
// single memory port is why a new input is taken only once the previous item
// has been written. A result waiting in the output register does not block
// acceptance of the next input. Slot 0 is the sentinel; the slot memory needs
// no clearing after reset because only slots already written by an add are
// ever used.
module free_list_record_slot_store
  import flrss_pkg::*;
#(
  parameter int SLOT_COUNT    = 1024,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // fields from bit 0: operation[2], slot_index[10], record_data[64], zero pad
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // fields from bit 0: status[2], slot_used[10], read_data[64], was_deleted[1],
  // live_records[10], zero pad
  output logic [OUT_W-1:0]      m_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam int WIDE_W = (CNT_W > SLOT_F_W) ? CNT_W : SLOT_F_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  typedef struct packed {
    logic                     live;
    logic [IDX_W-1:0]         link;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  // slot memory
  entry_t mem [SLOT_COUNT];
  entry_t mem_rd;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  // control and state registers
  logic                     state;
  logic [IDX_W-1:0]         free_head;
  logic [CNT_W-1:0]         slots_in_use;
  logic [IDX_W-1:0]         live_count;
  logic [1:0]               op;
  logic [WIDE_W-1:0]        idx;
  logic [PAYLOAD_WIDTH-1:0] data;

  logic                     in_fire;
  logic                     commit;

  // next values computed in the execute cycle
  logic [IDX_W-1:0]         free_head_next;
  logic [CNT_W-1:0]         slots_in_use_next;
  logic [IDX_W-1:0]         live_count_next;
  logic [STAT_W-1:0]        res_status;
  logic [WIDE_W-1:0]        res_used;
  logic [DATA_F_W-1:0]      res_data;
  logic                     res_deleted;
  logic [WIDE_W-1:0]        live_wide;

  logic [1:0]               in_op;
  logic [WIDE_W-1:0]        in_idx;
  logic                     idx_valid;

  assign in_op  = s_tdata[OP_W-1:0];
  assign in_idx = WIDE_W'(s_tdata[OP_W +: SLOT_F_W]);

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign commit   = (state == S_EXEC) && (!m_tvalid || m_tready);

  // read address: head of the free list for add, addressed slot otherwise
  assign mem_raddr = (in_op == OP_ADD) ? free_head : in_idx[IDX_W-1:0];

  // memory read port, registered data
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd <= mem[mem_raddr];
    end
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // slot addressed by delete or read lies in the used range
  assign idx_valid = (idx != '0) && (idx < WIDE_W'(slots_in_use));

  // execute: status, state update and write-back
  always_comb begin
    free_head_next    = free_head;
    slots_in_use_next = slots_in_use;
    live_count_next   = live_count;
    res_status        = ST_OK;
    res_used          = idx;
    res_data          = '0;
    res_deleted       = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = idx[IDX_W-1:0];
    mem_wdata         = mem_rd;
    case (op)
      OP_ADD: begin
        mem_wdata.live    = 1'b1;
        mem_wdata.link    = '0;
        mem_wdata.payload = data;
        if (free_head != '0) begin
          mem_waddr       = free_head;
          free_head_next  = mem_rd.link;
          res_used        = WIDE_W'(free_head);
          mem_we          = commit;
          live_count_next = live_count + 1'b1;
        end else if (slots_in_use < CNT_W'(SLOT_COUNT)) begin
          mem_waddr         = slots_in_use[IDX_W-1:0];
          slots_in_use_next = slots_in_use + 1'b1;
          res_used          = WIDE_W'(slots_in_use);
          mem_we            = commit;
          live_count_next   = live_count + 1'b1;
        end else begin
          res_status = ST_FULL;
          res_used   = '0;
        end
      end
      OP_DELETE: begin
        if (!idx_valid) begin
          res_status = ST_RANGE;
        end else if (!mem_rd.live) begin
          res_status = ST_DELETED;
        end else begin
          mem_wdata.live  = 1'b0;
          mem_wdata.link  = free_head;
          mem_we          = commit;
          free_head_next  = idx[IDX_W-1:0];
          live_count_next = live_count - 1'b1;
        end
      end
      OP_READ: begin
        if (!idx_valid) begin
          res_status = ST_RANGE;
        end else begin
          res_data    = DATA_F_W'(mem_rd.payload);
          res_deleted = !mem_rd.live;
        end
      end
      default: begin
        res_status = ST_RANGE;
      end
    endcase
  end

  assign live_wide = WIDE_W'(live_count_next);

  // sequencer and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      free_head    <= '0;
      slots_in_use <= CNT_W'(1);
      live_count   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state        <= S_IDLE;
            free_head    <= free_head_next;
            slots_in_use <= slots_in_use_next;
            live_count   <= live_count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op   <= in_op;
      idx  <= in_idx;
      data <= s_tdata[OP_W + SLOT_F_W +: PAYLOAD_WIDTH];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= OUT_W'({live_wide[SLOT_F_W-1:0], res_deleted, res_data,
                         res_used[SLOT_F_W-1:0], res_status});
    end
  end

endmodule

`default_nettype wire
